>>> src/aca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aca_pkg
// Shared types and constants of the address cache with aging: field widths,
// request kinds, result codes, register map, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package aca_pkg;

  localparam int KIND_W     = 2;
  localparam int PROTO_W    = 32;
  localparam int HW_W       = 48;
  localparam int STAMP_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int INDEX_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int STALE_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam int ENTRY_W    = PROTO_W + HW_W + STAMP_W;

  localparam logic [STALE_W-1:0]   STALE_RESET = 16'd15;
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = 5'd31;
  localparam logic [REG_IDX_W-1:0] REG_STALE_SECONDS = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_SWEEP  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_FINISH
  } aca_state_t;

  typedef struct packed {
    logic accept;
    logic ins_write;
    logic idx_step;
    logic scan_run;
    logic out_load;
  } aca_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic idx_last;
    logic scan_done;
    logic out_busy;
  } aca_sts_t;

endpackage
`default_nettype wire

>>> src/address_cache_with_aging.sv
`default_nettype none
// ----------------------------------------------------------------------------
// address_cache_with_aging
// Table of protocol to hardware address pairs with insert, lookup, second
// tick and stale-entry sweep requests, plus one aging register.
// ----------------------------------------------------------------------------
// One request is handled at a time. A tick goes from accept straight to
// the finish state. An insert walks the valid bits one slot per cycle and
// stops at the lowest free slot, or after the last slot when all are full.
// A lookup or a sweep reads the entry RAM one slot per cycle through its
// single read port and always visits every slot. The result register frees
// the controller, but the next request is taken only after the current
// result has been loaded there. Valid bits clear at reset; no clearing pass
// is needed. stale_seconds sits at byte address 0 and resets to 15.
// ----------------------------------------------------------------------------
module address_cache_with_aging #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [aca_pkg::KIND_W-1:0]        in_kind,
  input  logic [aca_pkg::PROTO_W-1:0]       in_proto_address,
  input  logic [aca_pkg::HW_W-1:0]          in_hw_address_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [aca_pkg::STATUS_W-1:0]      out_status,
  output logic [aca_pkg::INDEX_W-1:0]       out_entry_index,
  output logic [aca_pkg::HW_W-1:0]          out_hw_address_out,
  output logic [aca_pkg::COUNT_W-1:0]       out_invalidated_count,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [aca_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [aca_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [aca_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import aca_pkg::*;

  logic [STALE_W-1:0] stale_r;
  logic               reg_hit;
  logic               cfg_wr;
  aca_cmd_t           cmd;
  aca_sts_t           sts;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_STALE_SECONDS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_hit ? CFG_DATA_W'(stale_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= STALE_RESET;
    end else if (cfg_wr && reg_hit) begin
      stale_r <= cfg_pwdata[STALE_W-1:0];
    end
  end

  aca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aca_dpath #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_kind               (in_kind),
    .in_proto_address      (in_proto_address),
    .in_hw_address_in      (in_hw_address_in),
    .stale_seconds         (stale_r),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_entry_index       (out_entry_index),
    .out_hw_address_out    (out_hw_address_out),
    .out_invalidated_count (out_invalidated_count)
  );

endmodule
`default_nettype wire

>>> src/aca_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aca_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module aca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/aca_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aca_ctrl
// Controller of the address cache: takes a request, walks the slots for an
// insert or a lookup/sweep scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module aca_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [aca_pkg::KIND_W-1:0]    in_kind,
  output logic                          in_ready,
  input  aca_pkg::aca_sts_t             sts,
  output aca_pkg::aca_cmd_t             cmd
);
  import aca_pkg::*;

  aca_state_t state_r;
  aca_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (kind_t'(in_kind))
            KIND_INSERT: state_nxt = ST_INSERT;
            KIND_LOOKUP: state_nxt = ST_SCAN;
            KIND_TICK:   state_nxt = ST_FINISH;
            KIND_SWEEP:  state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_INSERT: begin
        if (sts.slot_free || sts.idx_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_INSERT: begin
        // first free slot wins, otherwise move on unless at the end
        if (sts.slot_free) begin
          cmd.ins_write = 1'b1;
        end else if (!sts.idx_last) begin
          cmd.idx_step = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = !sts.out_busy;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/aca_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aca_dpath
// Datapath of the address cache: request registers, second counter, valid
// bits, entry RAM, scan pointer with a one-stage read pipeline, result
// assembly and the output register.
// ----------------------------------------------------------------------------
module aca_dpath #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  aca_pkg::aca_cmd_t             cmd,
  output aca_pkg::aca_sts_t             sts,
  input  logic [aca_pkg::KIND_W-1:0]    in_kind,
  input  logic [aca_pkg::PROTO_W-1:0]   in_proto_address,
  input  logic [aca_pkg::HW_W-1:0]      in_hw_address_in,
  input  logic [aca_pkg::STALE_W-1:0]   stale_seconds,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aca_pkg::STATUS_W-1:0]  out_status,
  output logic [aca_pkg::INDEX_W-1:0]   out_entry_index,
  output logic [aca_pkg::HW_W-1:0]      out_hw_address_out,
  output logic [aca_pkg::COUNT_W-1:0]   out_invalidated_count
);
  import aca_pkg::*;

  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(CACHE_ENTRIES - 1);
  localparam logic [CW-1:0] END_IDX  = CW'(CACHE_ENTRIES);

  kind_t                    kind_r;
  logic [PROTO_W-1:0]       proto_r;
  logic [HW_W-1:0]          hw_r;
  logic [STAMP_W-1:0]       now_r;
  logic [CACHE_ENTRIES-1:0] valid_r;
  logic [CW-1:0]            idx_r;
  logic                     pend_r;
  logic [IW-1:0]            pidx_r;
  logic                     found_r;
  logic [IW-1:0]            found_idx_r;
  logic [HW_W-1:0]          found_hw_r;
  logic [COUNT_W-1:0]       count_r;
  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [INDEX_W-1:0]       out_index_r;
  logic [HW_W-1:0]          out_hw_r;
  logic [COUNT_W-1:0]       out_count_r;

  logic [IW-1:0]            idx_addr;
  logic                     scan_rd;
  logic [ENTRY_W-1:0]       entry_rd;
  logic [PROTO_W-1:0]       rd_proto;
  logic [HW_W-1:0]          rd_hw;
  logic [STAMP_W-1:0]       rd_stamp;
  logic [STAMP_W-1:0]       age;
  logic                     eval;
  logic                     lookup_match;
  logic                     sweep_kill;
  status_t                  res_status;
  logic [INDEX_W-1:0]       res_index;
  logic [HW_W-1:0]          res_hw;
  logic [COUNT_W-1:0]       res_count;

  assign idx_addr = idx_r[IW-1:0];
  assign scan_rd  = cmd.scan_run && (idx_r != END_IDX);

  aca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (idx_addr),
    .wdata ({proto_r, hw_r, now_r}),
    .re    (scan_rd),
    .raddr (idx_addr),
    .rdata (entry_rd)
  );

  assign rd_proto = entry_rd[ENTRY_W-1 -: PROTO_W];
  assign rd_hw    = entry_rd[STAMP_W +: HW_W];
  assign rd_stamp = entry_rd[STAMP_W-1:0];

  // age wraps with the second counter
  assign age  = now_r - rd_stamp;
  assign eval = pend_r && cmd.scan_run && valid_r[pidx_r];

  assign lookup_match = eval && (kind_r == KIND_LOOKUP) && (rd_proto == proto_r) && !found_r;
  assign sweep_kill   = eval && (kind_r == KIND_SWEEP) && (age > STAMP_W'(stale_seconds));

  assign sts.slot_free = !valid_r[idx_addr];
  assign sts.idx_last  = (idx_r == LAST_IDX);
  assign sts.scan_done = (idx_r == END_IDX) && !pend_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.ins_write) begin
        valid_r[idx_addr] <= 1'b1;
      end
      if (sweep_kill) begin
        valid_r[pidx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx_r   <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
        count_r <= '0;
        if (kind_t'(in_kind) == KIND_TICK) begin
          now_r <= now_r + STAMP_W'(1);
        end
      end
      if (cmd.idx_step) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.ins_write || lookup_match) begin
        found_r <= 1'b1;
      end
      // read one slot per cycle, evaluate it the cycle after
      if (cmd.scan_run) begin
        pend_r <= scan_rd;
        if (scan_rd) begin
          idx_r <= idx_r + CW'(1);
        end
      end
      if (sweep_kill && (count_r != COUNT_MAX)) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= kind_t'(in_kind);
      proto_r <= in_proto_address;
      hw_r    <= in_hw_address_in;
    end
    if (cmd.scan_run) begin
      pidx_r <= idx_addr;
    end
    if (cmd.ins_write) begin
      found_idx_r <= idx_addr;
    end
    if (lookup_match) begin
      found_idx_r <= pidx_r;
      found_hw_r  <= rd_hw;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_hw_r     <= res_hw;
      out_count_r  <= res_count;
    end
  end

  always_comb begin
    res_status = STATUS_OK;
    res_index  = '0;
    res_hw     = '0;
    res_count  = '0;
    unique case (kind_r)
      KIND_INSERT: begin
        res_status = found_r ? STATUS_OK : STATUS_FULL;
        res_index  = found_r ? INDEX_W'(found_idx_r) : '0;
      end
      KIND_LOOKUP: begin
        res_status = found_r ? STATUS_OK : STATUS_MISS;
        res_index  = found_r ? INDEX_W'(found_idx_r) : '0;
        res_hw     = found_r ? found_hw_r : '0;
      end
      KIND_TICK: begin
        res_status = STATUS_OK;
      end
      KIND_SWEEP: begin
        res_count = count_r;
      end
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_entry_index       = out_index_r;
  assign out_hw_address_out    = out_hw_r;
  assign out_invalidated_count = out_count_r;

endmodule
`default_nettype wire
